@@ design/xsr_pkg.sv @@
// package: payload types, constants, state encoding and the state-advance helper for the xorshift64* generator
`default_nettype none
package xsr_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] STAR_MUL     = 64'h2545_F491_4F6C_DD1D;
  localparam logic [63:0] SEED_RESET   = 64'h9E37_79B9_7F4A_7C15;

  localparam logic REQ_RAW     = 1'b0;
  localparam logic REQ_BOUNDED = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] bound_limit;
  } in_t;

  typedef struct packed {
    logic [63:0] random_value;
    logic        limit_error;
  } out_t;

  typedef enum logic [2:0] {
    ST_MIX_START,
    ST_MIX_A,
    ST_MIX_B,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [63:0] xs_advance(input logic [63:0] s);
    logic [63:0] x;
    x = s ^ (s >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

endpackage
`default_nettype wire

@@ design/xorshift64_star_bounded_rng.sv @@
// top level: xorshift64* generator with raw and bounded requests
// channels: in_valid/in_stall/in_data carries a request beat (req_type, bound_limit),
//   out_valid/out_stall/out_data carries one result beat (random_value, limit_error)
//   for every request, in order. cfg_we/cfg_wdata writes the seed; the state is then
//   re-mixed through splitmix64 before the next request is taken.
// path: a raw or zero-limit request goes through the three-pass 32x32 multiplier only;
//   a bounded request with a nonzero limit then also passes through the bit-serial
//   remainder unit.
// throughput: one request at a time; in_stall is high from accept until the result
//   has been moved into the output register.
// reset (rst_n low, synchronous): the seed returns to its default and the splitmix64
//   mix runs, with in_stall high, before the first request.
// receiver stall: the output register holds its beat while out_stall is high; the
//   next request may be accepted meanwhile, and its result waits until the slot frees.
`default_nettype none
module xorshift64_star_bounded_rng
  import xsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata
);

  state_t      state_r, state_nxt;
  logic [63:0] seed_r;
  logic [63:0] gen_r;
  logic        req_r;
  logic [31:0] lim_r;
  out_t        res_r;
  out_t        out_data_r;
  logic        out_valid_r;

  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic        div_start, div_done;
  logic [31:0] div_rem;
  logic        in_acc;
  logic        slot_free;
  logic [63:0] seed_z;
  logic [63:0] adv;

  assign seed_z    = seed_r + GOLDEN_GAMMA;
  assign adv       = xs_advance(gen_r);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  xsr_mul64 u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  xsr_div32 u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mul_p[63:32]),
    .divisor   (lim_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_MIX_START: state_nxt = ST_MIX_A;
      ST_MIX_A:     if (mul_done) state_nxt = ST_MIX_B;
      ST_MIX_B:     if (mul_done) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_valid) state_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = (req_r == REQ_BOUNDED && lim_r != 32'd0) ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV:       if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:      if (slot_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_MIX_START;
    endcase
    if (cfg_we) begin
      state_nxt = ST_MIX_START;
    end
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    mul_a     = adv;
    mul_b     = STAR_MUL;
    div_start = 1'b0;
    unique case (state_r)
      ST_MIX_START: begin
        mul_start = 1'b1;
        mul_a     = seed_z ^ (seed_z >> 30);
        mul_b     = MIX_MUL_A;
      end
      ST_MIX_A: begin
        mul_start = mul_done;
        mul_a     = mul_p ^ (mul_p >> 27);
        mul_b     = MIX_MUL_B;
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        mul_start = in_valid;
      end
      ST_MUL: begin
        div_start = mul_done && (req_r == REQ_BOUNDED) && (lim_r != 32'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_MIX_START;
      seed_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MIX_B && mul_done) begin
      gen_r <= mul_p ^ (mul_p >> 31);
    end else if (in_acc) begin
      gen_r <= adv;
    end
    if (in_acc) begin
      req_r <= in_data.req_type;
      lim_r <= in_data.bound_limit;
    end
    if (state_r == ST_MUL && mul_done) begin
      if (req_r == REQ_RAW) begin
        res_r.random_value <= mul_p;
        res_r.limit_error  <= 1'b0;
      end else begin
        res_r.random_value <= 64'd0;
        res_r.limit_error  <= (lim_r == 32'd0);
      end
    end else if (state_r == ST_DIV && div_done) begin
      res_r.random_value <= {32'd0, div_rem};
      res_r.limit_error  <= 1'b0;
    end
    if (state_r == ST_EMIT && slot_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ design/xsr_mul64.sv @@
// iterative 64x64 multiplier, low 64 bits of the product, one 32x32 multiply per cycle
`default_nettype none
module xsr_mul64
  import xsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] op_a,
  input  wire logic [63:0] op_b,
  output logic             done,
  output logic [63:0]      product
);

  logic [63:0] a_r, b_r;
  logic [63:0] m_r;
  logic [63:0] acc_r;
  logic [1:0]  cnt_r;
  logic [1:0]  msel_r;
  logic        run_r;
  logic        mvld_r;
  logic        done_r;
  logic [31:0] mul_x, mul_y;

  always_comb begin
    case (cnt_r)
      2'd0:    begin mul_x = a_r[31:0];  mul_y = b_r[31:0];  end
      2'd1:    begin mul_x = a_r[31:0];  mul_y = b_r[63:32]; end
      default: begin mul_x = a_r[63:32]; mul_y = b_r[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      mvld_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
      msel_r <= 2'd0;
    end else if (start) begin
      run_r  <= 1'b1;
      mvld_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      mvld_r <= run_r;
      msel_r <= cnt_r;
      done_r <= mvld_r && (msel_r == 2'd2);
      if (run_r) begin
        if (cnt_r == 2'd2) begin
          run_r <= 1'b0;
        end
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= 64'd0;
    end else begin
      m_r <= {32'd0, mul_x} * {32'd0, mul_y};
      if (mvld_r) begin
        if (msel_r == 2'd0) begin
          acc_r <= acc_r + m_r;
        end else begin
          acc_r[63:32] <= acc_r[63:32] + m_r[31:0];
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule
`default_nettype wire

@@ design/xsr_div32.sv @@
// restoring 32-bit divider, one quotient bit per cycle, remainder output
`default_nettype none
module xsr_div32
  import xsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      remainder
);

  logic [31:0] dvd_r, d_r, rem_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= run_r && (cnt_r == 5'd31);
      if (run_r) begin
        if (cnt_r == 5'd31) begin
          run_r <= 1'b0;
        end
        cnt_r <= cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      d_r   <= divisor;
      rem_r <= 32'd0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= diff[32] ? trial[31:0] : diff[31:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire
